// ===== rtl/core/set_assoc_search_table_assert.svh =====
`ifndef SET_ASSOC_SEARCH_TABLE_ASSERT_SVH
`define SET_ASSOC_SEARCH_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on the block clock, off while in reset.
`define SAST_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("set_assoc_search_table check failed");

// Next-cycle implication, sampled on the block clock, off while in reset.
`define SAST_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("set_assoc_search_table check failed");

`endif

// ===== rtl/core/sast_pkg.sv =====
package sast_pkg;

    // Table geometry.
    localparam int BUCKETS_DEF = 4096;
    localparam int WAYS        = 4;
    localparam int WAY_W       = 2;

    // Configuration reset value.
    localparam logic [14:0] MATE_RESET = 15'd29000;

    // Item kinds.
    localparam logic [1:0] KIND_PROBE = 2'd0;
    localparam logic [1:0] KIND_STORE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    // Bound types.
    localparam logic [1:0] FLAG_EXACT = 2'd0;
    localparam logic [1:0] FLAG_UPPER = 2'd1;
    localparam logic [1:0] FLAG_LOWER = 2'd2;

    // One way of a bucket.
    typedef struct packed {
        logic [63:0]        tag;
        logic signed [7:0]  depth;
        logic signed [15:0] score;
        logic [1:0]         flag;
        logic [15:0]        move;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    localparam way_t WAY_RESET = '{
        tag:   64'd0,
        depth: -8'sd1,
        score: 16'sd0,
        flag:  FLAG_EXACT,
        move:  16'd0
    };

    // Controller to datapath commands.
    typedef struct packed {
        logic clear_en;
        logic capture;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic clear_last;
    } dp_sts_t;

endpackage

// ===== rtl/core/sast_dpath.sv =====
module sast_dpath #(
    parameter int BUCKETS = sast_pkg::BUCKETS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  sast_pkg::dp_cmd_t  cmd,
    output sast_pkg::dp_sts_t  sts,
    input  logic               cfg_we,
    input  logic [14:0]        cfg_mate_threshold,
    input  logic [1:0]         s_kind,
    input  logic [63:0]        s_key_hash,
    input  logic [6:0]         s_search_depth,
    input  logic signed [15:0] s_alpha_bound,
    input  logic signed [15:0] s_beta_bound,
    input  logic [6:0]         s_ply_from_root,
    input  logic signed [15:0] s_store_score,
    input  logic [1:0]         s_store_flag,
    input  logic [15:0]        s_store_move,
    output logic               m_hit,
    output logic signed [15:0] m_hit_score,
    output logic [15:0]        m_best_move
);
    import sast_pkg::*;

    localparam int IDX_W = $clog2(BUCKETS);

    // Probe side: move a mate score back toward the node by the ply.
    function automatic logic signed [15:0] probe_adj(
        input logic signed [15:0] score,
        input logic [14:0]        thr,
        input logic [6:0]         ply
    );
        logic signed [16:0] s17;
        logic signed [16:0] t17;
        logic signed [16:0] p17;
        logic signed [16:0] r17;
        s17 = $signed({score[15], score});
        t17 = $signed({2'b00, thr});
        p17 = $signed({10'd0, ply});
        if (s17 > t17) begin
            r17 = s17 - p17;
        end else if (s17 < -t17) begin
            r17 = s17 + p17;
        end else begin
            r17 = s17;
        end
        return r17[15:0];
    endfunction

    // Store side: move a mate score away from zero by the ply, then saturate.
    function automatic logic signed [15:0] store_adj(
        input logic signed [15:0] score,
        input logic [14:0]        thr,
        input logic [6:0]         ply
    );
        logic signed [16:0] s17;
        logic signed [16:0] t17;
        logic signed [16:0] p17;
        logic signed [16:0] r17;
        s17 = $signed({score[15], score});
        t17 = $signed({2'b00, thr});
        p17 = $signed({10'd0, ply});
        if (s17 > t17) begin
            r17 = s17 + p17;
        end else if (s17 < -t17) begin
            r17 = s17 - p17;
        end else begin
            r17 = s17;
        end
        if (r17 > 17'sd32767) begin
            return 16'sh7FFF;
        end else if (r17 < -17'sd32768) begin
            return 16'sh8000;
        end else begin
            return r17[15:0];
        end
    endfunction

    // Configuration register.
    logic [14:0] thr_reg;

    // Captured item fields.
    logic [1:0]         kind_reg;
    logic [63:0]        key_reg;
    logic [6:0]         depth_reg;
    logic signed [15:0] alpha_reg;
    logic signed [15:0] beta_reg;
    logic [6:0]         ply_reg;
    logic signed [15:0] sscore_reg;
    logic [1:0]         sflag_reg;
    logic [15:0]        smove_reg;

    // Bucket memory, read data register and clearing counter.
    row_t             bucket_mem [BUCKETS];
    row_t             rd_row_reg;
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;

    // Result registers.
    logic               hit_reg;
    logic signed [15:0] score_reg;
    logic [15:0]        move_reg;

    // Per-way compare results.
    logic [WAYS-1:0]    tag_eq;
    logic [WAYS-1:0]    way_empty;
    logic [WAYS-1:0]    deep_enough;
    logic [WAYS-1:0]    bound_pass;
    logic signed [15:0] adj_score [WAYS];

    // Selection results.
    logic               probe_hit;
    logic signed [15:0] probe_score;
    logic               match_found;
    logic [WAY_W-1:0]   match_way;
    logic [15:0]        query_move;
    logic               empty_found;
    logic [WAY_W-1:0]   empty_way;
    logic [WAY_W-1:0]   shallow_way;
    logic [WAY_W-1:0]   victim_way;
    row_t               wr_row;

    // Memory write port.
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    row_t             mem_wdata;

    // The threshold register takes a write whenever one is offered.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= MATE_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_mate_threshold;
        end
    end

    // Capture the item fields when it is accepted.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg   <= s_kind;
            key_reg    <= s_key_hash;
            depth_reg  <= s_search_depth;
            alpha_reg  <= s_alpha_bound;
            beta_reg   <= s_beta_bound;
            ply_reg    <= s_ply_from_root;
            sscore_reg <= s_store_score;
            sflag_reg  <= s_store_flag;
            smove_reg  <= s_store_move;
        end
    end

    // The clearing counter walks every bucket once after reset.
    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (cmd.clear_en) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    assign sts.clear_last = (clr_cnt_reg == IDX_W'(BUCKETS - 1));

    // Compare every way of the bucket in parallel.
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            adj_score[w]   = probe_adj(rd_row_reg[w].score, thr_reg, ply_reg);
            tag_eq[w]      = (rd_row_reg[w].tag == key_reg);
            way_empty[w]   = (rd_row_reg[w].tag == 64'd0);
            deep_enough[w] = (rd_row_reg[w].depth >= $signed({1'b0, depth_reg}));
            case (rd_row_reg[w].flag)
                FLAG_EXACT: bound_pass[w] = 1'b1;
                FLAG_UPPER: bound_pass[w] = (adj_score[w] <= alpha_reg);
                FLAG_LOWER: bound_pass[w] = (adj_score[w] >= beta_reg);
                default:    bound_pass[w] = 1'b0;
            endcase
        end
    end

    // Pick the first usable, first matching and first empty ways.
    always_comb begin
        probe_hit   = 1'b0;
        probe_score = 16'sd0;
        match_found = 1'b0;
        match_way   = '0;
        query_move  = 16'd0;
        empty_found = 1'b0;
        empty_way   = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (tag_eq[w] && deep_enough[w] && bound_pass[w] && !probe_hit) begin
                probe_hit   = 1'b1;
                probe_score = adj_score[w];
            end
            if (tag_eq[w] && !match_found) begin
                match_found = 1'b1;
                match_way   = WAY_W'(w);
                query_move  = rd_row_reg[w].move;
            end
            if (way_empty[w] && !empty_found) begin
                empty_found = 1'b1;
                empty_way   = WAY_W'(w);
            end
        end
    end

    // Shallowest way, lowest index on a tie.
    always_comb begin
        shallow_way = '0;
        for (int w = 1; w < WAYS; w++) begin
            if (rd_row_reg[w].depth < rd_row_reg[shallow_way].depth) begin
                shallow_way = WAY_W'(w);
            end
        end
    end

    // Replacement choice and the updated bucket.
    always_comb begin
        if (match_found) begin
            victim_way = match_way;
        end else if (empty_found) begin
            victim_way = empty_way;
        end else begin
            victim_way = shallow_way;
        end
        wr_row = rd_row_reg;
        wr_row[victim_way] = '{
            tag:   key_reg,
            depth: $signed({1'b0, depth_reg}),
            score: store_adj(sscore_reg, thr_reg, ply_reg),
            flag:  sflag_reg,
            move:  smove_reg
        };
    end

    // Write port: clearing pass or store writeback.
    always_comb begin
        mem_we    = cmd.clear_en || (cmd.finish && (kind_reg == KIND_STORE));
        mem_waddr = cmd.clear_en ? clr_cnt_reg : key_reg[IDX_W-1:0];
        mem_wdata = cmd.clear_en ? row_t'({WAYS{WAY_RESET}}) : wr_row;
    end

    // Bucket memory with a registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bucket_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture) begin
            rd_row_reg <= bucket_mem[s_key_hash[IDX_W-1:0]];
        end
    end

    // Result registers load when the item finishes.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            hit_reg   <= (kind_reg == KIND_PROBE) && probe_hit;
            score_reg <= ((kind_reg == KIND_PROBE) && probe_hit) ? probe_score : 16'sd0;
            move_reg  <= (kind_reg == KIND_QUERY) ? query_move : 16'd0;
        end
    end

    assign m_hit       = hit_reg;
    assign m_hit_score = score_reg;
    assign m_best_move = move_reg;

endmodule

// ===== rtl/core/sast_ctrl.sv =====
module sast_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output sast_pkg::dp_cmd_t cmd,
    input  sast_pkg::dp_sts_t sts
);
    import sast_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_LOOK  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    // Commands to the datapath.
    always_comb begin
        cmd.clear_en = (state_reg == ST_CLEAR);
        cmd.capture  = (state_reg == ST_IDLE) && s_valid;
        cmd.finish   = (state_reg == ST_LOOK) && (!out_valid_reg || m_ready);
    end

    // Next state: clear the table, then take one item at a time.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (cmd.finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // The result stays valid until it is taken; a new one can replace it then.
    always_comb begin
        if (cmd.finish) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;

endmodule

// ===== rtl/core/set_assoc_search_table.sv =====
// Results: an item is accepted in the idle state and compared in the look state; its
// result is registered when it finishes, which waits while the previous result is untaken.
// Flow: one item at a time; an item reads its bucket when it is accepted,
// and the next item's bucket read waits for this item's writeback.
// Reset: synchronous, active low; afterwards a clearing pass writes all BUCKETS
// buckets with s_ready low; config writes are always taken.
module set_assoc_search_table #(
    parameter int BUCKETS = sast_pkg::BUCKETS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [14:0]        cfg_mate_threshold,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic [63:0]        s_key_hash,
    input  logic [6:0]         s_search_depth,
    input  logic signed [15:0] s_alpha_bound,
    input  logic signed [15:0] s_beta_bound,
    input  logic [6:0]         s_ply_from_root,
    input  logic signed [15:0] s_store_score,
    input  logic [1:0]         s_store_flag,
    input  logic [15:0]        s_store_move,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic signed [15:0] m_hit_score,
    output logic [15:0]        m_best_move
);
    import sast_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // The threshold register can be written in any cycle.
    assign cfg_ready = 1'b1;

    // Sequencer.
    sast_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Table memory, way compare and result registers.
    sast_dpath #(
        .BUCKETS (BUCKETS)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_valid),
        .cfg_mate_threshold (cfg_mate_threshold),
        .s_kind             (s_kind),
        .s_key_hash         (s_key_hash),
        .s_search_depth     (s_search_depth),
        .s_alpha_bound      (s_alpha_bound),
        .s_beta_bound       (s_beta_bound),
        .s_ply_from_root    (s_ply_from_root),
        .s_store_score      (s_store_score),
        .s_store_flag       (s_store_flag),
        .s_store_move       (s_store_move),
        .m_hit              (m_hit),
        .m_hit_score        (m_hit_score),
        .m_best_move        (m_best_move)
    );

endmodule

// ===== rtl/core/sast_checker.sv =====
module sast_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_hit,
    input logic signed [15:0] m_hit_score,
    input logic [15:0]        m_best_move
);
    `include "set_assoc_search_table_assert.svh"

    // A stalled result stays offered.
    `SAST_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid)

    // Only one item is at work at a time.
    `SAST_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready)

    // A probe hit never carries a move.
    `SAST_ASSERT_NOW(a_hit_no_move, m_valid && m_hit, m_best_move == 16'd0)

    // Without a hit the score is zero.
    `SAST_ASSERT_NOW(a_miss_zero, m_valid && !m_hit, m_hit_score == 16'sd0)

endmodule

bind set_assoc_search_table sast_checker u_sast_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_hit       (m_hit),
    .m_hit_score (m_hit_score),
    .m_best_move (m_best_move)
);
